// ===== sv/dsg_pkg.sv =====
// Shared types and constants of the direct-sum gravity step block.
package dsg_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        mass;
  } body_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] REG_GRAVITY   = 2'd0;
  localparam logic [1:0] REG_SOFTENING = 2'd1;
  localparam logic [1:0] REG_TIME_STEP = 2'd2;

  // Serial divider: quotient bits and divisor width.
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 50;

endpackage

// ===== sv/dsg_cell.sv =====
// One body slot of the rotating body ring.
module dsg_cell import dsg_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  body_t      next_i,
  input  body_t      load_i,
  output body_t      body_o
);

  body_t body_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      body_q <= load_i;
    end else if (ctrl_i.shift) begin
      body_q <= next_i;
    end
  end

  assign body_o = body_q;

endmodule

// ===== sv/dsg_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dsg_div import dsg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIV_NW-1:0] quo_o
);

  localparam int CntW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/dsg_isqrt.sv =====
// Integer square root, one result bit per cycle.
module dsg_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic        busy_q;
  logic        done_q;
  logic [63:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= rad_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== sv/direct_sum_gravity_step.sv =====
// Direct-sum 2-D gravity step: body ring, pair engine and output register.
// Load: the result beat is registered one cycle after the input beat.
// Step with n bodies: each pair at distinct positions takes three divides, one square root
// and serial multiplies, with ring rotations to bring each pivot body round; then each body
// gets its position update and output, which output stalls can hold.
// One item is in work at a time. Reset empties the store and restores the registers.
module direct_sum_gravity_step import dsg_pkg::*; #(
  parameter int MAX_BODIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [30:0]        mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         body_index_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic [1:0]         status_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);

  localparam int SW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  localparam logic [5:0] S_IDLE = 6'd0,  S_PIVOT = 6'd1,  S_PAIR = 6'd2,  S_BACK = 6'd3;
  localparam logic [5:0] S_NEXT_I = 6'd4, S_DIFF = 6'd5,  S_MX = 6'd6,    S_MY = 6'd7;
  localparam logic [5:0] S_D2 = 6'd8,    S_INV_W = 6'd9,  S_M1 = 6'd10,   S_M2 = 6'd11;
  localparam logic [5:0] S_M3 = 6'd12,   S_M4 = 6'd13,    S_M5 = 6'd14,   S_S1 = 6'd15;
  localparam logic [5:0] S_S2 = 6'd16,   S_S3 = 6'd17,    S_SQ_W = 6'd18, S_UX = 6'd19;
  localparam logic [5:0] S_UX_W = 6'd20, S_UY = 6'd21,    S_UY_W = 6'd22, S_V1 = 6'd23;
  localparam logic [5:0] S_V2 = 6'd24,   S_V3 = 6'd25,    S_V4 = 6'd26,   S_V5 = 6'd27;
  localparam logic [5:0] S_WB = 6'd28,   S_ADV = 6'd29,   S_POS = 6'd30,  S_P1 = 6'd31;
  localparam logic [5:0] S_P2 = 6'd32,   S_P3 = 6'd33,    S_P4 = 6'd34,   S_P5 = 6'd35;
  localparam logic [5:0] S_HOME = 6'd36;

  function automatic logic [31:0] sat_u32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // v + mag or v - mag, saturated to 32-bit signed; mag stays below 2^48.
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] v,
                                                 input logic [63:0] mag,
                                                 input logic sub);
    logic signed [63:0] s;
    s = sub ? (64'(v) - $signed(mag)) : (64'(v) + $signed(mag));
    if (s > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  logic [5:0]    state_q;
  logic [SW-1:0] head_q;
  logic [SW-1:0] i_q;
  logic [CW-1:0] count_q;
  logic [30:0]   grav_q, soft_q, ts_q;

  body_t         ring [MAX_BODIES];
  body_t         head, pivot_q, head_data, cell_load;
  logic          rotate, head_wr, load_wr;

  logic          dx_neg_q, dy_neg_q;
  logic [31:0]   ax_q, ay_q, inv_q, ai_q, aj_q, len_q;
  logic [30:0]   sx_q, sy_q;
  logic [16:0]   ux_q, uy_q;
  logic signed [31:0] hvx_q, hvy_q, npx_q, npy_q;
  logic [63:0]   prod_q, acc_q;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mag;
  logic [31:0]   mag_sat;

  logic signed [32:0] dx, dy;
  logic [31:0]   ax, ay;
  logic [63:0]   d2sum;
  logic [DIV_DW-1:0] denom;

  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic              sq_start, sq_busy, sq_done;
  logic [31:0]       sq_root;

  logic          in_acc, out_free, emit;
  logic          out_valid_q;
  logic [5:0]    emit_idx;
  logic signed [31:0] emit_px, emit_py, emit_vx, emit_vy;
  logic [1:0]    emit_status;
  logic          emit_last;
  logic [SW+5:0] head_ext, count_ext;
  logic          head_last;

  assign head = ring[0];

  // Body ring: cell k takes the body of cell k+1 on a rotation; cell 0 is the head.
  for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
    localparam int Nxt = (k + 1) % MAX_BODIES;
    cell_ctrl_t ctrl;
    assign ctrl.shift = rotate;
    assign ctrl.load  = ((k == 0) && head_wr) || (load_wr && (count_q == CW'(k)));
    dsg_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .next_i (ring[Nxt]),
      .load_i (cell_load),
      .body_o (ring[k])
    );
  end

  assign cell_load = head_wr ? head_data
                             : body_t'{pos_x: pos_x_i, pos_y: pos_y_i, vel_x: vel_x_i,
                                       vel_y: vel_y_i, mass: mass_i};

  dsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  dsg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_q + prod_q),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign dx    = $signed({pivot_q.pos_x[31], pivot_q.pos_x})
               - $signed({head.pos_x[31], head.pos_x});
  assign dy    = $signed({pivot_q.pos_y[31], pivot_q.pos_y})
               - $signed({head.pos_y[31], head.pos_y});
  assign ax    = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay    = dy[32] ? 32'(-dy) : dy[31:0];
  assign d2sum = acc_q + (prod_q >> 16) + 64'(soft_q);
  // A zero denominator counts as one.
  assign denom = (d2sum == '0) ? DIV_DW'(1) : d2sum[DIV_DW-1:0];
  assign mag     = prod_q >> 16;
  assign mag_sat = sat_u32(mag);

  assign head_ext  = {6'b0, head_q};
  assign count_ext = {6'b0, count_q[SW-1:0]};
  assign head_last = (CW'(head_q) + CW'(1)) == count_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MX:    begin mul_a = ax_q;             mul_b = ax_q; end
      S_MY:    begin mul_a = ay_q;             mul_b = ay_q; end
      S_M1:    begin mul_a = {1'b0, head.mass}; mul_b = inv_q; end
      S_M2, S_M4: begin mul_a = mag_sat;       mul_b = {1'b0, ts_q}; end
      S_M3:    begin mul_a = {1'b0, pivot_q.mass}; mul_b = inv_q; end
      S_S1:    begin mul_a = {1'b0, sx_q};     mul_b = {1'b0, sx_q}; end
      S_S2:    begin mul_a = {1'b0, sy_q};     mul_b = {1'b0, sy_q}; end
      S_V1:    begin mul_a = 32'(ux_q);        mul_b = ai_q; end
      S_V2:    begin mul_a = 32'(uy_q);        mul_b = ai_q; end
      S_V3:    begin mul_a = 32'(ux_q);        mul_b = aj_q; end
      S_V4:    begin mul_a = 32'(uy_q);        mul_b = aj_q; end
      S_P1:    begin mul_a = abs32(head.vel_x); mul_b = {1'b0, ts_q}; end
      S_P2:    begin mul_a = abs32(head.vel_y); mul_b = {1'b0, ts_q}; end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  // Control decode.
  always_comb begin
    rotate      = 1'b0;
    head_wr     = 1'b0;
    head_data   = head;
    load_wr     = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    sq_start    = 1'b0;
    emit        = 1'b0;
    emit_idx    = '0;
    emit_px     = '0;
    emit_py     = '0;
    emit_vx     = '0;
    emit_vy     = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          if (op_i == OP_LOAD) begin
            if (count_q >= CW'(MAX_BODIES)) begin
              emit_status = ST_FULL;
            end else begin
              load_wr  = 1'b1;
              emit_idx = count_ext[5:0];
              emit_px  = pos_x_i;
              emit_py  = pos_y_i;
              emit_vx  = vel_x_i;
              emit_vy  = vel_y_i;
            end
          end else if (count_q == '0) begin
            emit_status = ST_EMPTY;
          end else begin
            emit = 1'b0;
          end
        end
      end
      S_PIVOT, S_NEXT_I, S_ADV, S_P5: rotate = 1'b1;
      S_BACK: begin
        if (head_q == i_q) begin
          head_wr   = 1'b1;
          head_data = pivot_q;
        end else begin
          rotate = 1'b1;
        end
      end
      S_D2: begin
        div_start = 1'b1;
        div_num   = {1'b0, grav_q, 16'b0};
        div_den   = denom;
      end
      S_S3: sq_start = 1'b1;
      S_UX: begin
        div_start = 1'b1;
        div_num   = {1'b0, sx_q, 16'b0};
        div_den   = DIV_DW'(len_q);
      end
      S_UY: begin
        div_start = 1'b1;
        div_num   = {1'b0, sy_q, 16'b0};
        div_den   = DIV_DW'(len_q);
      end
      S_WB: begin
        head_wr         = 1'b1;
        head_data.vel_x = hvx_q;
        head_data.vel_y = hvy_q;
      end
      S_POS, S_HOME: rotate = (head_q != '0);
      S_P4: begin
        if (out_free) begin
          head_wr         = 1'b1;
          head_data.pos_x = npx_q;
          head_data.pos_y = npy_q;
          emit            = 1'b1;
          emit_idx        = head_ext[5:0];
          emit_px         = npx_q;
          emit_py         = npy_q;
          emit_vx         = head.vel_x;
          emit_vy         = head.vel_y;
          emit_last       = head_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      i_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      grav_q      <= 31'd65536;
      soft_q      <= 31'd655;
      ts_q        <= 31'd655;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRAVITY:   grav_q <= cfg_data_i;
          REG_SOFTENING: soft_q <= cfg_data_i;
          REG_TIME_STEP: ts_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_wr) begin
        count_q <= count_q + 1'b1;
      end
      if (rotate) begin
        head_q <= (head_q == SW'(MAX_BODIES - 1)) ? '0 : head_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && op_i == OP_STEP && count_q != '0) begin
            i_q     <= '0;
            state_q <= (count_q == CW'(1)) ? S_P1 : S_PIVOT;
          end
        end
        S_PIVOT: state_q <= S_PAIR;
        S_PAIR: begin
          if (CW'(head_q) > CW'(i_q) && CW'(head_q) < count_q) begin
            state_q <= S_DIFF;
          end else begin
            state_q <= S_BACK;
          end
        end
        S_BACK:   if (head_q == i_q) state_q <= S_NEXT_I;
        S_NEXT_I: begin
          i_q     <= i_q + 1'b1;
          state_q <= ((CW'(i_q) + CW'(2)) == count_q) ? S_POS : S_PIVOT;
        end
        S_DIFF:   state_q <= (ax == '0 && ay == '0) ? S_ADV : S_MX;
        S_MX:     state_q <= S_MY;
        S_MY:     state_q <= S_D2;
        S_D2:     state_q <= S_INV_W;
        S_INV_W:  if (div_done) state_q <= S_M1;
        S_M1:     state_q <= S_M2;
        S_M2:     state_q <= S_M3;
        S_M3:     state_q <= S_M4;
        S_M4:     state_q <= S_M5;
        S_M5:     state_q <= S_S1;
        S_S1:     state_q <= S_S2;
        S_S2:     state_q <= S_S3;
        S_S3:     state_q <= S_SQ_W;
        S_SQ_W:   if (sq_done) state_q <= S_UX;
        S_UX:     state_q <= S_UX_W;
        S_UX_W:   if (div_done) state_q <= S_UY;
        S_UY:     state_q <= S_UY_W;
        S_UY_W:   if (div_done) state_q <= S_V1;
        S_V1:     state_q <= S_V2;
        S_V2:     state_q <= S_V3;
        S_V3:     state_q <= S_V4;
        S_V4:     state_q <= S_V5;
        S_V5:     state_q <= S_WB;
        S_WB:     state_q <= S_ADV;
        S_ADV:    state_q <= S_PAIR;
        S_POS:    if (head_q == '0) state_q <= S_P1;
        S_P1:     state_q <= S_P2;
        S_P2:     state_q <= S_P3;
        S_P3:     state_q <= S_P4;
        S_P4:     if (out_free) state_q <= S_P5;
        S_P5:     state_q <= head_last ? S_HOME : S_P1;
        S_HOME:   if (head_q == '0) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (emit) begin
      body_index_o <= emit_idx;
      out_pos_x_o  <= emit_px;
      out_pos_y_o  <= emit_py;
      out_vel_x_o  <= emit_vx;
      out_vel_y_o  <= emit_vy;
      status_o     <= emit_status;
      last_o       <= emit_last;
    end
    case (state_q)
      S_PIVOT: pivot_q <= head;
      S_DIFF: begin
        dx_neg_q <= dx[32];
        dy_neg_q <= dy[32];
        ax_q     <= ax;
        ay_q     <= ay;
      end
      S_MY:    acc_q <= prod_q >> 16;
      S_INV_W: inv_q <= sat_u32(64'(div_quo));
      S_M3:    ai_q  <= mag_sat;
      S_M5: begin
        aj_q <= mag_sat;
        // Large separations are halved so the squared length fits.
        if (ax_q[31] || ay_q[31]) begin
          sx_q <= ax_q[31:1];
          sy_q <= ay_q[31:1];
        end else begin
          sx_q <= ax_q[30:0];
          sy_q <= ay_q[30:0];
        end
      end
      S_S2:    acc_q <= prod_q;
      S_SQ_W:  len_q <= sq_root;
      S_UX_W:  ux_q  <= div_quo[16:0];
      S_UY_W:  uy_q  <= div_quo[16:0];
      S_V2:    pivot_q.vel_x <= add_sat(pivot_q.vel_x, mag, !dx_neg_q);
      S_V3:    pivot_q.vel_y <= add_sat(pivot_q.vel_y, mag, !dy_neg_q);
      S_V4:    hvx_q <= add_sat(head.vel_x, mag, dx_neg_q);
      S_V5:    hvy_q <= add_sat(head.vel_y, mag, dy_neg_q);
      S_P2:    npx_q <= add_sat(head.pos_x, mag, head.vel_x[31]);
      S_P3:    npy_q <= add_sat(head.pos_y, mag, head.vel_y[31]);
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> head_q == '0) else $error("ring not at home while idle");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BODIES)) else $error("body count beyond store size");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_sq_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy) else $error("square root started while busy");
  a_ring_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rotate |-> !(head_wr || load_wr)) else $error("ring written during rotation");

endmodule

// ===== bench/direct_sum_gravity_step_checker.sv =====
// Checker for the gravity step block: predicts the body stream and compares every result beat.
module direct_sum_gravity_step_checker import dsg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [30:0]        mass_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [5:0]         body_index_i,
  input  logic signed [31:0] out_pos_x_i,
  input  logic signed [31:0] out_pos_y_i,
  input  logic signed [31:0] out_vel_x_i,
  input  logic signed [31:0] out_vel_y_i,
  input  logic [1:0]         status_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] px, py, vx, vy;
    logic [1:0]         status;
    logic               last;
  } body_beat_t;

  body_beat_t expected_beats[$];

  logic [30:0]        gravity, softening, time_step;
  logic signed [31:0] bx[NB], by[NB], bvx[NB], bvy[NB];
  logic [30:0]        bmass[NB];
  int                 body_count;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [31:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned clamp_u32(longint unsigned v);
    return v > U32_MAX ? U32_MAX : v;
  endfunction

  // Signed Q16.16 product, truncated toward zero.
  function automatic longint scale_q16(longint v, longint unsigned s);
    longint m;
    m = longint'((mag(v) * s) >> 16);
    return v < 0 ? -m : m;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pull_of(logic [30:0] m, longint unsigned inv);
    longint unsigned p;
    p = clamp_u32((longint'(m) * inv) >> 16);
    return clamp_u32((p * time_step) >> 16);
  endfunction

  task automatic pair_pull(int i, int j);
    longint dx, dy, ux, uy;
    longint unsigned ax, ay, denom, inv, ai, aj, sx, sy, len;
    dx = longint'(bx[i]) - longint'(bx[j]);
    dy = longint'(by[i]) - longint'(by[j]);
    ax = mag(dx);
    ay = mag(dy);
    if (ax == 0 && ay == 0) return;
    denom = ((ax * ax) >> 16) + ((ay * ay) >> 16) + softening;
    if (denom == 0) denom = 1;
    inv = clamp_u32((longint'(gravity) << 16) / denom);
    ai = pull_of(bmass[j], inv);
    aj = pull_of(bmass[i], inv);
    sx = ax;
    sy = ay;
    // Halve far separations so the squared length fits in 64 bits.
    if (sx >= 64'h8000_0000 || sy >= 64'h8000_0000) begin
      sx >>= 1;
      sy >>= 1;
    end
    len = floor_sqrt(sx * sx + sy * sy);
    if (len == 0) return;
    ux = longint'((sx << 16) / len);
    uy = longint'((sy << 16) / len);
    if (dx < 0) ux = -ux;
    if (dy < 0) uy = -uy;
    bvx[i] = clamp_s32(longint'(bvx[i]) - scale_q16(ux, ai));
    bvy[i] = clamp_s32(longint'(bvy[i]) - scale_q16(uy, ai));
    bvx[j] = clamp_s32(longint'(bvx[j]) + scale_q16(ux, aj));
    bvy[j] = clamp_s32(longint'(bvy[j]) + scale_q16(uy, aj));
  endtask

  task automatic push_beat(int idx, logic signed [31:0] px, py, vx, vy,
                           logic [1:0] st, logic lst);
    body_beat_t b;
    b.index = idx[5:0];
    b.px = px; b.py = py; b.vx = vx; b.vy = vy;
    b.status = st;
    b.last = lst;
    expected_beats.push_back(b);
  endtask

  task automatic predict_item();
    if (op_i == OP_LOAD) begin
      if (body_count >= NB) begin
        push_beat(0, 0, 0, 0, 0, ST_FULL, 1'b1);
      end else begin
        bx[body_count] = pos_x_i;
        by[body_count] = pos_y_i;
        bvx[body_count] = vel_x_i;
        bvy[body_count] = vel_y_i;
        bmass[body_count] = mass_i;
        push_beat(body_count, pos_x_i, pos_y_i, vel_x_i, vel_y_i, ST_OK, 1'b1);
        body_count++;
      end
    end else if (body_count == 0) begin
      push_beat(0, 0, 0, 0, 0, ST_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < body_count; i++)
        for (int j = i + 1; j < body_count; j++)
          pair_pull(i, j);
      for (int i = 0; i < body_count; i++) begin
        bx[i] = clamp_s32(longint'(bx[i]) + scale_q16(bvx[i], time_step));
        by[i] = clamp_s32(longint'(by[i]) + scale_q16(bvy[i], time_step));
        push_beat(i, bx[i], by[i], bvx[i], bvy[i], ST_OK, i + 1 == body_count);
      end
    end
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      errors_o++;
    end
  endtask

  task automatic check_beat();
    body_beat_t e;
    if (expected_beats.size() == 0) begin
      $display("%0t ns: unexpected result beat, index %0d status %0d",
               $time, body_index_i, status_i);
      errors_o++;
      return;
    end
    e = expected_beats.pop_front();
    check_field("body_index", e.index, body_index_i);
    check_field("out_pos_x", e.px, out_pos_x_i);
    check_field("out_pos_y", e.py, out_pos_y_i);
    check_field("out_vel_x", e.vx, out_vel_x_i);
    check_field("out_vel_y", e.vy, out_vel_y_i);
    check_field("status", e.status, status_i);
    check_field("last", e.last, last_i);
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity = 31'd65536;
      softening = 31'd655;
      time_step = 31'd655;
      body_count = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRAVITY:   gravity = cfg_data_i;
          REG_SOFTENING: softening = cfg_data_i;
          REG_TIME_STEP: time_step = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_item();
      if (out_valid_i && out_ready_i) check_beat();
    end
    pending_o = expected_beats.size();
  end

endmodule

// ===== bench/direct_sum_gravity_step_test.sv =====
// Top of the gravity step testbench: clock, reset, stimulus, sink stalls and verdict.
module direct_sum_gravity_step_test import dsg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP_RANDOM = 9;
  localparam int WATCHDOG_LIMIT = 2_000_000;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o, op_i;
  logic signed [31:0] pos_x_i, pos_y_i, vel_x_i, vel_y_i;
  logic [30:0]        mass_i;
  logic               out_valid_o, out_ready_i;
  logic [5:0]         body_index_o;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_vel_x_o, out_vel_y_o;
  logic [1:0]         status_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [30:0]        cfg_data_i;

  int errors, pending, loaded, silent_cycles;
  bit calm;

  direct_sum_gravity_step dut (.*);

  direct_sum_gravity_step_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i,
    .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i, .mass_i,
    .out_valid_i(out_valid_o), .out_ready_i, .body_index_i(body_index_o),
    .out_pos_x_i(out_pos_x_o), .out_pos_y_i(out_pos_y_o),
    .out_vel_x_i(out_vel_x_o), .out_vel_y_i(out_vel_y_o),
    .status_i(status_o), .last_i(last_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) silent_cycles = 0;
    else silent_cycles++;
    if (silent_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [31:0] px, py, vx, vy, logic [30:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i = op;
    pos_x_i = px; pos_y_i = py; vel_x_i = vx; vel_y_i = vy;
    mass_i = m;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD && loaded < 64) loaded++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [30:0] g, s, t);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = REG_GRAVITY;   cfg_data_i = g; @(negedge clk_i);
    cfg_idx_i = REG_SOFTENING; cfg_data_i = s; @(negedge clk_i);
    cfg_idx_i = REG_TIME_STEP; cfg_data_i = t; @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Most coordinates are local so that the bodies interact, some span the whole range.
  function automatic logic signed [31:0] rand_coord(int spread);
    logic signed [31:0] v;
    if ($urandom_range(3) == 0) return $urandom;
    v = $urandom_range(spread);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_random_load();
    send_item(OP_LOAD, rand_coord(1 << 20), rand_coord(1 << 20),
              rand_coord(1 << 17), rand_coord(1 << 17), 31'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_LOAD;
    pos_x_i = '0; pos_y_i = '0; vel_x_i = '0; vel_y_i = '0;
    mass_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_GRAVITY;
    cfg_data_i = '0;
    loaded = 0;
    silent_cycles = 0;
    calm = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty step, coincident pair, a vanishing denominator, far extremes.
    send_item(OP_STEP, 0, 0, 0, 0, 0);
    write_regs(31'd65536, 31'd0, 31'd655);
    send_item(OP_LOAD, 0, 0, 0, 0, 31'h7FFF_FFFF);
    send_item(OP_LOAD, 0, 0, 0, 0, 31'd65536);
    send_item(OP_LOAD, 1, 0, 0, 0, 31'd1);
    send_item(OP_STEP, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              31'd0);
    send_item(OP_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              31'h7FFF_FFFF);
    send_item(OP_STEP, 0, 0, 0, 0, 0);
    write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_STEP, 0, 0, 0, 0, 0);
    write_regs(31'd0, 31'd0, 31'd0);
    send_item(OP_STEP, 0, 0, 0, 0, 0);

    // Random part in four settings, each ending with a stretch of calm traffic.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_regs(31'd65536, 31'd655, 31'd655);
        1: write_regs(31'($urandom_range(1 << 22)), 31'($urandom_range(1 << 20)),
                      31'($urandom_range(1 << 15)));
        2: write_regs(31'h7FFF_FFFF, 31'($urandom), 31'h7FFF_FFFF);
        default: write_regs(31'($urandom), 31'd0, 31'($urandom_range(1 << 12)));
      endcase
      for (int k = 0; k < 18; k++) begin
        calm = (k >= 13);
        if (loaded < CAP_RANDOM && $urandom_range(1)) send_random_load();
        else send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, 31'($urandom));
      end
      calm = 1'b0;
    end

    // Fill the store, take one full-size step, then overflow it.
    write_regs(31'd65536, 31'd655, 31'd655);
    while (loaded < 64) send_random_load();
    send_item(OP_STEP, 0, 0, 0, 0, 0);
    send_random_load();
    send_random_load();

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
